// File: design/nwgs_pkg.sv
// Package for the nearest waypoint guide select block.
// Holds the item structs, command and register codes, and shared constants.
// No dependencies.
`default_nettype none

package nwgs_pkg;

    // Default path depth and configuration reset values.
    localparam int unsigned MAX_POINTS_DEF = 1024;
    localparam logic [10:0] LOOKAHEAD_RST  = 11'd10;
    localparam logic [42:0] MATCH_RST      = 43'd10000000000;

    // Offsets used when picking the near reference point.
    localparam int unsigned NEAR_STEP  = 1;
    localparam int unsigned NEAR_GUARD = 6;

    // Function codes of an input item.
    localparam logic [1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [1:0] FUNC_APPEND = 2'd1;
    localparam logic [1:0] FUNC_QUERY  = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_LOOKAHEAD = 1'b0;
    localparam logic CFG_MATCH     = 1'b1;

    // One input item.
    typedef struct packed {
        logic [1:0]         func;
        logic signed [19:0] point_x;
        logic signed [19:0] point_y;
        logic signed [15:0] point_heading;
        logic signed [19:0] pos_x;
        logic signed [19:0] pos_y;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic signed [19:0] ref_x;
        logic signed [19:0] ref_y;
        logic signed [15:0] ref_heading;
        logic signed [19:0] way_x;
        logic signed [19:0] way_y;
        logic signed [15:0] way_heading;
        logic [9:0]         nearest_index;
        logic               matched;
        logic               path_empty;
    } t_out_item;

    // One stored path point.
    typedef struct packed {
        logic signed [19:0] x;
        logic signed [19:0] y;
        logic signed [15:0] h;
    } t_point;

    // Classified command passed from the front end to the engine.
    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_QUERY  = 2'd2
    } t_op;

    typedef struct packed {
        t_op    op;
        t_point pt;
    } t_cmd;

endpackage

`default_nettype wire

// File: design/nwgs_front.sv
// Front end: accepts input items, classifies them and queues commands.
// Depends on nwgs_pkg for the item and command types.
`default_nettype none

module nwgs_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire nwgs_pkg::t_in_item i_in_item,
    output nwgs_pkg::t_cmd         o_cmd,
    output logic                   o_cmd_valid,
    input  wire logic              i_cmd_take
);
    import nwgs_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_cmd       n_cmd;
    logic       n_keep;
    logic       w_acc;
    logic       w_take;

    // Classify the incoming item; an unused function code is dropped.
    always_comb begin
        n_cmd  = '0;
        n_keep = 1'b1;
        case (i_in_item.func)
            FUNC_CLEAR: begin
                n_cmd.op = OP_CLEAR;
            end
            FUNC_APPEND: begin
                n_cmd.op   = OP_APPEND;
                n_cmd.pt.x = i_in_item.point_x;
                n_cmd.pt.y = i_in_item.point_y;
                n_cmd.pt.h = i_in_item.point_heading;
            end
            FUNC_QUERY: begin
                n_cmd.op   = OP_QUERY;
                n_cmd.pt.x = i_in_item.pos_x;
                n_cmd.pt.y = i_in_item.pos_y;
            end
            default: begin
                n_keep = 1'b0;
            end
        endcase
    end

    assign full        = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign w_acc       = push && !full && n_keep;
    assign w_take      = i_cmd_take && o_cmd_valid;

    // Two-entry command queue between the front end and the engine.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_acc) begin
                r_wp <= !r_wp;
            end
            if (w_take) begin
                r_rp <= !r_rp;
            end
            if (w_acc && !w_take) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!w_acc && w_take) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    // Queue storage carries payload only.
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_q[r_wp] <= n_cmd;
        end
    end

endmodule

`default_nettype wire

// File: design/nwgs_back.sv
// Engine: holds the path memory, carries out commands and scans for queries.
// Depends on nwgs_pkg for the command, point and result types.
`default_nettype none

module nwgs_back #(
    parameter int unsigned MAX_POINTS = nwgs_pkg::MAX_POINTS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire nwgs_pkg::t_cmd     i_cmd,
    input  wire logic               i_cmd_valid,
    output logic                    o_cmd_take,
    input  wire logic [10:0]        i_lookahead,
    input  wire logic [42:0]        i_match,
    output nwgs_pkg::t_out_item     o_out_item,
    output logic                    o_out_valid,
    input  wire logic               i_pop
);
    import nwgs_pkg::*;

    localparam int unsigned CW = $clog2(MAX_POINTS + 1);
    localparam int unsigned IW = $clog2(MAX_POINTS);
    localparam int unsigned SW = ((CW > 11) ? CW : 11) + 1;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_DRAIN = 6'b000100,
        S_RDREF = 6'b001000,
        S_RDWAY = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_point             r_mem [MAX_POINTS];
    t_point             r_rd;
    t_state             r_state;
    logic [CW-1:0]      r_count;
    logic [IW-1:0]      r_scan_idx;
    logic signed [19:0] r_pos_x;
    logic signed [19:0] r_pos_y;
    logic               r_qempty;
    logic               r_v1;
    logic               r_v2;
    logic               r_v3;
    logic [IW-1:0]      r_i1;
    logic [IW-1:0]      r_i2;
    logic [IW-1:0]      r_i3;
    logic signed [20:0] r_dx;
    logic signed [20:0] r_dy;
    logic [40:0]        r_sqx;
    logic [40:0]        r_sqy;
    logic [42:0]        r_best;
    logic [IW-1:0]      r_nearest;
    logic               r_hit;
    logic [IW-1:0]      r_ref_id;
    logic [IW-1:0]      r_way_id;
    t_point             r_ref_pt;
    t_out_item          r_out;
    logic               r_out_valid;

    logic [IW-1:0]      w_rd_addr;
    logic [CW-1:0]      w_last;
    logic               w_mem_we;
    logic signed [41:0] w_px;
    logic signed [41:0] w_py;
    logic [42:0]        w_dist;
    logic [SW-1:0]      w_guard;
    logic [SW-1:0]      w_step;
    logic [SW-1:0]      w_ahead;
    logic [SW-1:0]      w_last_ext;
    logic [IW-1:0]      n_ref_id;
    logic [IW-1:0]      n_way_id;
    logic [IW+9:0]      w_near_ext;
    logic               w_slot_free;
    t_out_item          n_out;

    assign w_last      = r_count - CW'(1);
    assign o_cmd_take  = i_cmd_valid && (r_state == S_IDLE);
    assign w_mem_we    = o_cmd_take && (i_cmd.op == OP_APPEND) &&
                         (r_count < CW'(MAX_POINTS));
    assign w_slot_free = !r_out_valid || i_pop;
    assign o_out_item  = r_out;
    assign o_out_valid = r_out_valid;

    // Read address follows the phase of the query.
    always_comb begin
        case (r_state)
            S_SCAN:  w_rd_addr = r_scan_idx;
            S_RDREF: w_rd_addr = r_ref_id;
            default: w_rd_addr = r_way_id;
        endcase
    end

    // Path memory with a single write port and a registered read port.
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[r_count[IW-1:0]] <= i_cmd.pt;
        end
        r_rd <= r_mem[w_rd_addr];
    end

    // Squared distance terms and their sum.
    assign w_px   = r_dx * r_dx;
    assign w_py   = r_dy * r_dy;
    assign w_dist = {2'b00, r_sqx} + {2'b00, r_sqy};

    // Near and lookahead indexes, clamped to the last stored point.
    assign w_last_ext = SW'(w_last);
    assign w_guard    = SW'(r_nearest) + SW'(NEAR_GUARD);
    assign w_step     = SW'(r_nearest) + SW'(NEAR_STEP);
    assign w_ahead    = SW'(r_nearest) + SW'(i_lookahead);
    always_comb begin
        n_ref_id = w_last[IW-1:0];
        n_way_id = w_last[IW-1:0];
        if (r_hit) begin
            if (w_guard <= w_last_ext) begin
                n_ref_id = w_step[IW-1:0];
            end
            if (w_ahead <= w_last_ext) begin
                n_way_id = w_ahead[IW-1:0];
            end
        end
    end

    // Result assembly; an empty path gives zeros with the empty flag.
    assign w_near_ext = (IW + 10)'(r_nearest);
    always_comb begin
        n_out = '0;
        if (r_qempty) begin
            n_out.path_empty = 1'b1;
        end else begin
            n_out.ref_x         = r_ref_pt.x;
            n_out.ref_y         = r_ref_pt.y;
            n_out.ref_heading   = r_ref_pt.h;
            n_out.way_x         = r_rd.x;
            n_out.way_y         = r_rd.y;
            n_out.way_heading   = r_rd.h;
            n_out.nearest_index = r_hit ? w_near_ext[9:0] : 10'd0;
            n_out.matched       = r_hit;
        end
    end

    // Sequencer, scan control and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_v1 <= (r_state == S_SCAN);
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            // The result register fills from a finished query and empties on a pop.
            if (r_state == S_DONE && w_slot_free) begin
                r_out_valid <= 1'b1;
            end else if (i_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_cmd_take) begin
                        case (i_cmd.op)
                            OP_CLEAR: begin
                                r_count <= '0;
                            end
                            OP_APPEND: begin
                                if (w_mem_we) begin
                                    r_count <= r_count + CW'(1);
                                end
                            end
                            OP_QUERY: begin
                                r_state <= (r_count == '0) ? S_DONE : S_SCAN;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (r_scan_idx == w_last[IW-1:0]) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (!r_v1 && !r_v2 && !r_v3) begin
                        r_state <= S_RDREF;
                    end
                end
                S_RDREF: begin
                    r_state <= S_RDWAY;
                end
                S_RDWAY: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_slot_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers: scan pipeline, best match and read captures.
    always_ff @(posedge i_clk) begin
        // Query set-up.
        if (r_state == S_IDLE && o_cmd_take && i_cmd.op == OP_QUERY) begin
            r_pos_x    <= i_cmd.pt.x;
            r_pos_y    <= i_cmd.pt.y;
            r_qempty   <= (r_count == '0);
            r_scan_idx <= '0;
            r_best     <= i_match;
            r_nearest  <= '0;
            r_hit      <= 1'b0;
        end else if (r_state == S_SCAN) begin
            r_scan_idx <= r_scan_idx + IW'(1);
        end
        // Stage one: coordinate differences.
        r_i1 <= r_scan_idx;
        r_i2 <= r_i1;
        r_i3 <= r_i2;
        r_dx <= {r_pos_x[19], r_pos_x} - {r_rd.x[19], r_rd.x};
        r_dy <= {r_pos_y[19], r_pos_y} - {r_rd.y[19], r_rd.y};
        // Stage two: squares.
        r_sqx <= w_px[40:0];
        r_sqy <= w_py[40:0];
        // Stage three: strict compare keeps the first of equal distances.
        if (r_v3 && (w_dist < r_best)) begin
            r_best    <= w_dist;
            r_nearest <= r_i3;
            r_hit     <= 1'b1;
        end
        if (r_state == S_DRAIN) begin
            r_ref_id <= n_ref_id;
            r_way_id <= n_way_id;
        end
        if (r_state == S_RDWAY) begin
            r_ref_pt <= r_rd;
        end
        if (r_state == S_DONE && w_slot_free) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

// File: design/nearest_waypoint_guide_select_top.sv
// Top level of the nearest waypoint guide select block.
// Depends on nwgs_pkg, nwgs_front and nwgs_back; holds the configuration registers.
//
// Usage: items enter through a queue-style input (push, full); a transaction
// completes when push is high and full is low. Results leave through a
// queue-style output (empty, pop); the oldest result sits on o_out_item while
// empty is low and is taken when pop is high. Clear, append and query items
// share one input; only a query gives a result. Configuration is written
// through i_cfg_wr_en, i_cfg_index and i_cfg_data; the user must write it
// only while the block is idle, which the block itself does not enforce.
// Query flow: one memory read per stored point in the scan, three pipeline
// stages of difference, square and compare, then reads of the near and
// lookahead points; a query on an empty path skips the scan and the reads.
// A two-entry command queue lets input transactions land while a query runs.
// Reset clears the point count, the queues and the configuration registers;
// the path memory keeps its contents but is unreachable until rewritten.
// When the receiver stalls, a finished result waits in the output register
// while clears and appends continue; the next query waits to be delivered.
`default_nettype none

module nearest_waypoint_guide_select_top #(
    parameter int unsigned MAX_POINTS = nwgs_pkg::MAX_POINTS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire nwgs_pkg::t_in_item  i_in_item,
    output logic                     empty,
    input  wire logic                pop,
    output nwgs_pkg::t_out_item      o_out_item,
    input  wire logic                i_cfg_wr_en,
    input  wire logic                i_cfg_index,
    input  wire logic [42:0]         i_cfg_data
);
    import nwgs_pkg::*;

    logic [10:0] r_lookahead;
    logic [42:0] r_match;
    t_cmd        w_cmd;
    logic        w_cmd_valid;
    logic        w_cmd_take;
    logic        w_out_valid;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lookahead <= LOOKAHEAD_RST;
            r_match     <= MATCH_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_LOOKAHEAD: r_lookahead <= i_cfg_data[10:0];
                CFG_MATCH:     r_match     <= i_cfg_data;
                default:       r_match     <= r_match;
            endcase
        end
    end

    // Front end: accept and classify.
    nwgs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in_item   (i_in_item),
        .o_cmd       (w_cmd),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_take  (w_cmd_take)
    );

    // Engine: path memory, scan and result register.
    nwgs_back #(
        .MAX_POINTS (MAX_POINTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_take  (w_cmd_take),
        .i_lookahead (r_lookahead),
        .i_match     (r_match),
        .o_out_item  (o_out_item),
        .o_out_valid (w_out_valid),
        .i_pop       (pop)
    );

    assign empty = !w_out_valid;

endmodule

`default_nettype wire

// File: tb/tb.sv
// Testbench for nearest_waypoint_guide_select_top: drives clear, append and query transactions,
// predicts every guide result from its own copy of the path and checks each one on the output.
// Depends on nwgs_pkg and the design files only.
module tb;
    import nwgs_pkg::*;

    localparam int unsigned DEPTH       = MAX_POINTS_DEF;
    localparam int unsigned CYCLE_LIMIT = 2000000;
    localparam int unsigned PHASE_ITEMS = 80;
    localparam int unsigned LONG_LEN    = 160;
    localparam logic [1:0]  FUNC_UNUSED = 2'd3;
    localparam logic [42:0] MATCH_MAX   = 43'h7FF_FFFF_FFFF;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        push        = 1'b0;
    logic        full;
    t_in_item    i_in_item   = '0;
    logic        empty;
    logic        pop         = 1'b0;
    t_out_item   o_out_item;
    logic        i_cfg_wr_en = 1'b0;
    logic        i_cfg_index = CFG_LOOKAHEAD;
    logic [42:0] i_cfg_data  = '0;

    // Predictor copy of the stored path and of the configuration.
    t_point      path_pts [DEPTH];
    int unsigned path_len      = 0;
    logic [10:0] lookahead_cfg = LOOKAHEAD_RST;
    logic [42:0] match_thr_cfg = MATCH_RST;
    t_out_item   pending_guides [$];

    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          hold_cycles    = 0;
    int          guide_errors   = 0;
    int unsigned cycle_count    = 0;

    nearest_waypoint_guide_select_top #(
        .MAX_POINTS(DEPTH)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_item  (i_in_item),
        .empty      (empty),
        .pop        (pop),
        .o_out_item (o_out_item),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    // Clock with a period of ten units.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Expected guide for a query position, from the current path and configuration.
    function automatic t_out_item guide_for_position(input logic signed [19:0] qx,
                                                      input logic signed [19:0] qy);
        t_out_item   g;
        longint      dx, dy, d_sq, best;
        int unsigned near_idx, last_idx, ref_idx, way_idx, i;
        bit          hit;
        g = '0;
        if (path_len == 0) begin
            g.path_empty = 1'b1;
            return g;
        end
        best     = longint'(match_thr_cfg);
        hit      = 1'b0;
        near_idx = 0;
        for (i = 0; i < path_len; i++) begin
            dx   = longint'(qx) - longint'(path_pts[i].x);
            dy   = longint'(qy) - longint'(path_pts[i].y);
            d_sq = dx * dx + dy * dy;
            // Strictly below keeps the first of equal distances.
            if (d_sq < best) begin
                best     = d_sq;
                near_idx = i;
                hit      = 1'b1;
            end
        end
        last_idx = path_len - 1;
        if (hit) begin
            ref_idx = (near_idx + NEAR_GUARD > last_idx) ? last_idx : near_idx + NEAR_STEP;
            way_idx = (near_idx + lookahead_cfg > last_idx) ? last_idx
                                                           : near_idx + lookahead_cfg;
        end else begin
            ref_idx = last_idx;
            way_idx = last_idx;
        end
        g.ref_x         = path_pts[ref_idx].x;
        g.ref_y         = path_pts[ref_idx].y;
        g.ref_heading   = path_pts[ref_idx].h;
        g.way_x         = path_pts[way_idx].x;
        g.way_y         = path_pts[way_idx].y;
        g.way_heading   = path_pts[way_idx].h;
        g.nearest_index = hit ? 10'(near_idx) : '0;
        g.matched       = hit;
        return g;
    endfunction

    task automatic flag_failure(input string msg);
        guide_errors++;
        if (guide_errors <= 10) begin
            $display("Mismatch at cycle %0d: %s", cycle_count, msg);
        end
    endtask

    task automatic compare_field(input string what, input logic signed [63:0] want,
                                 input logic signed [63:0] got);
        if (got !== want) begin
            flag_failure($sformatf("%s expected %0d, got %0d", what, want, got));
        end
    endtask

    // Compare one delivered guide with the oldest outstanding expectation.
    task automatic check_guide(input t_out_item got);
        t_out_item want;
        if (pending_guides.size() == 0) begin
            flag_failure("result transaction with no query outstanding");
            return;
        end
        want = pending_guides.pop_front();
        compare_field("ref_x", want.ref_x, got.ref_x);
        compare_field("ref_y", want.ref_y, got.ref_y);
        compare_field("ref_heading", want.ref_heading, got.ref_heading);
        compare_field("way_x", want.way_x, got.way_x);
        compare_field("way_y", want.way_y, got.way_y);
        compare_field("way_heading", want.way_heading, got.way_heading);
        compare_field("nearest_index", want.nearest_index, got.nearest_index);
        compare_field("matched", want.matched, got.matched);
        compare_field("path_empty", want.path_empty, got.path_empty);
    endtask

    // Receiver: checks each result transaction, then decides whether to pop next cycle.
    // A requested hold-off is counted down here on each clock edge.
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            check_guide(o_out_item);
        end
        if (hold_cycles > 0) begin
            hold_cycles = hold_cycles - 1;
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog on the total run length.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    // Offer one item with a random gap before it and update the predictor on acceptance.
    // Push is left high afterwards; every other time-consuming task lowers it first.
    task automatic offer_item(input t_in_item item);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push      <= 1'b1;
        i_in_item <= item;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        case (item.func)
            FUNC_CLEAR: begin
                path_len = 0;
            end
            FUNC_APPEND: begin
                // Appends to a full path are dropped.
                if (path_len < DEPTH) begin
                    path_pts[path_len].x = item.point_x;
                    path_pts[path_len].y = item.point_y;
                    path_pts[path_len].h = item.point_heading;
                    path_len++;
                end
            end
            FUNC_QUERY: begin
                pending_guides.insert(pending_guides.size(),
                                      guide_for_position(item.pos_x, item.pos_y));
            end
            default: begin
            end
        endcase
    endtask

    // Wait until every expected result has been taken and the engine has settled.
    task automatic wait_drained();
        push <= 1'b0;
        while (pending_guides.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    // Write both registers while the block is idle.
    task automatic configure(input logic [10:0] la, input logic [42:0] thr);
        wait_drained();
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_LOOKAHEAD;
        i_cfg_data  <= 43'(la);
        @(posedge i_clk);
        i_cfg_index <= CFG_MATCH;
        i_cfg_data  <= thr;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        lookahead_cfg = la;
        match_thr_cfg = thr;
    endtask

    // An item of the given function with every other field random.
    function automatic t_in_item rand_item(input logic [1:0] func);
        t_in_item item;
        item.func          = func;
        item.point_x       = 20'($urandom);
        item.point_y       = 20'($urandom);
        item.point_heading = 16'($urandom);
        item.pos_x         = 20'($urandom);
        item.pos_y         = 20'($urandom);
        return item;
    endfunction

    // Mostly within -25736 to 25736, now and then any 16-bit value.
    function automatic logic signed [15:0] rand_heading();
        if ($urandom_range(15) == 0) begin
            return 16'($urandom);
        end
        return 16'(int'($urandom_range(51472)) - 25736);
    endfunction

    // Random offset within +-spread, saturated to the coordinate range.
    function automatic logic signed [19:0] nudge(input logic signed [19:0] c, input int spread);
        int v;
        v = int'(c) + int'($urandom_range(2 * spread)) - spread;
        if (v > 524287) begin
            v = 524287;
        end
        if (v < -524288) begin
            v = -524288;
        end
        return 20'(v);
    endfunction

    task automatic clear_path();
        offer_item(rand_item(FUNC_CLEAR));
    endtask

    task automatic append_point(input logic signed [19:0] x, input logic signed [19:0] y,
                                input logic signed [15:0] h);
        t_in_item item;
        item               = rand_item(FUNC_APPEND);
        item.point_x       = x;
        item.point_y       = y;
        item.point_heading = h;
        offer_item(item);
    endtask

    task automatic query_at(input logic signed [19:0] x, input logic signed [19:0] y);
        t_in_item item;
        item       = rand_item(FUNC_QUERY);
        item.pos_x = x;
        item.pos_y = y;
        offer_item(item);
    endtask

    // Query near a random stored point, or anywhere when the path is empty.
    task automatic query_near_path(input int spread);
        int unsigned idx;
        if (path_len == 0) begin
            query_at(20'($urandom), 20'($urandom));
        end else begin
            idx = $urandom_range(path_len - 1);
            query_at(nudge(path_pts[idx].x, spread), nudge(path_pts[idx].y, spread));
        end
    endtask

    // Queries on an empty path, before and after a clear, and an unused function code.
    task automatic test_empty_path();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        query_at(20'sd0, 20'sd0);
        offer_item(rand_item(FUNC_UNUSED));
        query_at(20'($urandom), 20'($urandom));
        clear_path();
        query_at(20'sd524287, -20'sd524288);
    endtask

    // Coordinate and heading extremes, a tie, clamping at the end of the path,
    // no match, and lookaheads of 0 and 1024 with the match threshold at both extremes.
    task automatic test_corner_points();
        append_point(-20'sd524288, -20'sd524288, -16'sd25736);
        append_point(20'sd524287, 20'sd524287, 16'sd25736);
        append_point(20'sd0, 20'sd0, -16'sd32768);
        append_point(20'sd0, 20'sd0, 16'sd32767);
        append_point(20'sd3000, 20'sd0, 16'sd100);
        append_point(20'sd6000, 20'sd0, 16'sd200);
        append_point(20'sd9000, 20'sd0, 16'sd300);
        append_point(20'sd12000, 20'sd0, 16'sd400);
        query_at(-20'sd524288, -20'sd524288);
        query_at(20'sd524287, 20'sd524287);
        query_at(20'sd0, 20'sd0);
        query_at(-20'sd524288, 20'sd524287);
        configure(11'd0, MATCH_MAX);
        query_at(20'sd524287, -20'sd524288);
        query_at(20'sd3100, 20'sd0);
        configure(11'd1024, 43'd0);
        query_at(20'sd0, 20'sd0);
        configure(LOOKAHEAD_RST, MATCH_RST);
    endtask

    // The receiver holds off for a long stretch while queries keep arriving,
    // so the block fills up and raises full.
    task automatic test_backpressure();
        logic signed [19:0] cx, cy;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        cx = 20'sd0;
        cy = 20'sd0;
        clear_path();
        repeat (12) begin
            cx = nudge(cx, 2000);
            cy = nudge(cy, 2000);
            append_point(cx, cy, rand_heading());
        end
        hold_cycles = 400;
        for (int n = 0; n < 20; n++) begin
            if (n % 4 == 3) begin
                append_point(nudge(cx, 2000), nudge(cy, 2000), rand_heading());
            end else begin
                query_near_path(500);
            end
        end
    endtask

    // One phase of random traffic: mostly well-formed paths with queries near them,
    // the rest noise, unused codes and appends onto an old path.
    task automatic run_random_phase(input int send_pct, input int recv_pct,
                                    input logic [10:0] la, input logic [42:0] thr);
        int unsigned        counted, roll, k, q, spread_sel;
        logic signed [19:0] cx, cy;
        logic signed [15:0] ch;
        configure(la, thr);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        counted = 0;
        while (counted < PHASE_ITEMS) begin
            roll = $urandom_range(99);
            if (roll < 8) begin
                offer_item(rand_item(FUNC_UNUSED));
            end else if (roll < 14) begin
                query_at(20'($urandom), 20'($urandom));
                counted++;
            end else begin
                if ($urandom_range(9) != 0 || path_len + 40 > DEPTH) begin
                    clear_path();
                    counted++;
                end
                cx = 20'($urandom);
                cy = 20'($urandom);
                ch = rand_heading();
                k  = $urandom_range(40);
                repeat (k) begin
                    // Now and then a repeated point to make a tie.
                    if ($urandom_range(9) != 0) begin
                        cx = ($urandom_range(15) == 0) ? 20'($urandom) : nudge(cx, 2000);
                        cy = nudge(cy, 2000);
                        ch = rand_heading();
                    end
                    append_point(cx, cy, ch);
                end
                counted += k;
                q = $urandom_range(1, 6);
                repeat (q) begin
                    spread_sel = $urandom_range(3);
                    case (spread_sel)
                        0:       query_near_path(0);
                        1:       query_near_path(500);
                        2:       query_near_path(3000);
                        default: query_near_path(120000);
                    endcase
                end
                counted += q;
            end
        end
    endtask

    task automatic test_random_traffic();
        run_random_phase(0, 0, LOOKAHEAD_RST, MATCH_RST);
        run_random_phase(80, 0, 11'($urandom_range(12)), 43'd4000000);
        run_random_phase(0, 80, 11'($urandom_range(1024)), 43'({$urandom, $urandom}));
        run_random_phase(36, 36, 11'd5, 43'd25000000);
    endtask

    // Build a long path and query at both ends and in the middle with
    // lookaheads of 1024 and 0.
    task automatic test_long_path();
        send_idle_pct  = 0;
        recv_stall_pct = 36;
        configure(11'd1024, MATCH_MAX);
        clear_path();
        for (int i = 0; i < LONG_LEN; i++) begin
            append_point(20'(-460000 + i * 900), nudge(20'sd0, 300), rand_heading());
        end
        query_at(path_pts[0].x, path_pts[0].y);
        query_at(path_pts[LONG_LEN - 1].x, path_pts[LONG_LEN - 1].y);
        query_at(path_pts[100].x, nudge(path_pts[100].y, 200));
        configure(11'd0, MATCH_RST);
        query_at(path_pts[120].x, path_pts[120].y);
        query_at(-20'sd524288, 20'sd524287);
        configure(LOOKAHEAD_RST, MATCH_RST);
        query_at(path_pts[155].x, path_pts[155].y);
        clear_path();
    endtask

    // Reset, then each test in turn, then the final verdict.
    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_path();
        test_corner_points();
        test_backpressure();
        test_random_traffic();
        test_long_path();
        wait_drained();
        repeat (32) @(posedge i_clk);
        if (guide_errors == 0 && pending_guides.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
